@@ sv/tbwe_pkg.sv @@
// ----------------------------------------------------------------------------
// tbwe_pkg
// Shared constants, filter coefficients and fixed-point helpers of the
// three band waveform energy unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tbwe_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int CF         = 28;                   // coefficient fraction bits
  localparam int DF         = 11;                   // fraction bits below sample lsb
  localparam int SIG_W      = SAMPLE_W + 2 + DF;    // section output
  localparam int DLY_W      = SAMPLE_W + 4 + DF;    // section delay
  localparam int BAND_W     = SIG_W - DF;           // band value in sample lsbs
  localparam int SQ_W       = 2 * BAND_W - 1;
  localparam int ACC_W      = 48;                   // band square sum
  localparam int MUL_W      = 32;
  localparam int MAC_W      = 64;
  localparam int CNT_W      = 16;
  localparam int PEAK_W     = SAMPLE_W + 1;
  localparam int HG_W       = 16;
  localparam int BG_W       = 18;
  localparam int CFG_W      = 18;
  localparam int CFG_ADDR_W = 2;
  localparam int ROOT_W     = ACC_W / 2;
  localparam int GAIN_SHIFT = SAMPLE_W - 1 + 8;
  localparam int HEIGHT_W   = 5;
  localparam int LEVEL_W    = 7;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_FLD_W  = HEIGHT_W + 3 * LEVEL_W;
  localparam int OUT_DATA_W = 32;
  localparam int NSEC       = 4;

  localparam logic [CNT_W-1:0] SPC_RESET = 16'd294;
  localparam logic [HG_W-1:0]  HG_RESET  = 16'd11110;
  localparam logic [BG_W-1:0]  BG_RESET  = 18'd97536;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_SPC = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HG  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_BG  = 2'd2;

  // filter sections
  localparam logic [1:0] SEC_LP200 = 2'd0;
  localparam logic [1:0] SEC_HP200 = 2'd1;
  localparam logic [1:0] SEC_LP2K  = 2'd2;
  localparam logic [1:0] SEC_HP2K  = 2'd3;

  // coefficient slots
  localparam logic [2:0] K_B0 = 3'd0;
  localparam logic [2:0] K_B1 = 3'd1;
  localparam logic [2:0] K_B2 = 3'd2;
  localparam logic [2:0] K_A1 = 3'd3;
  localparam logic [2:0] K_A2 = 3'd4;

  localparam logic signed [MAC_W-1:0] HALF_CF = 64'sd1 <<< (CF - 1);
  localparam logic signed [MAC_W-1:0] HALF_G  = 64'sd1 <<< (GAIN_SHIFT - 1);
  localparam logic signed [MAC_W-1:0] SIG_MAX = (64'sd1 <<< (SIG_W - 1)) - 64'sd1;
  localparam logic signed [MAC_W-1:0] SIG_MIN = -SIG_MAX - 64'sd1;
  localparam logic signed [MAC_W-1:0] DLY_MAX = (64'sd1 <<< (DLY_W - 1)) - 64'sd1;
  localparam logic signed [MAC_W-1:0] DLY_MIN = -DLY_MAX - 64'sd1;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB,
    ACC_LOADADD
  } acc_op_t;

  typedef struct packed {
    logic    mul_en;
    acc_op_t op;
  } mac_cmd_t;

  // rbj designs at 44.1 kHz, q = 0.707, held in q2.30 and rounded to q4.CF
  function automatic logic signed [MUL_W-1:0] coef_q(input logic [1:0] sec,
                                                     input logic [2:0] k);
    logic signed [MAC_W-1:0] q30;
    logic signed [MAC_W-1:0] r;
    unique case ({sec, k})
      {SEC_LP200, K_B0}: q30 = 64'sd213643;
      {SEC_LP200, K_B1}: q30 = 64'sd427287;
      {SEC_LP200, K_B2}: q30 = 64'sd213643;
      {SEC_LP200, K_A1}: q30 = -64'sd2104213127;
      {SEC_LP200, K_A2}: q30 = 64'sd1031325876;
      {SEC_HP200, K_B0}: q30 = 64'sd1052320207;
      {SEC_HP200, K_B1}: q30 = -64'sd2104640413;
      {SEC_HP200, K_B2}: q30 = 64'sd1052320207;
      {SEC_HP200, K_A1}: q30 = -64'sd2104213127;
      {SEC_HP200, K_A2}: q30 = 64'sd1031325876;
      {SEC_LP2K,  K_B0}: q30 = 64'sd18058974;
      {SEC_LP2K,  K_B1}: q30 = 64'sd36117947;
      {SEC_LP2K,  K_B2}: q30 = 64'sd18058974;
      {SEC_LP2K,  K_A1}: q30 = -64'sd1719116810;
      {SEC_LP2K,  K_A2}: q30 = 64'sd717610881;
      {SEC_HP2K,  K_B0}: q30 = 64'sd877617379;
      {SEC_HP2K,  K_B1}: q30 = -64'sd1755234758;
      {SEC_HP2K,  K_B2}: q30 = 64'sd877617379;
      {SEC_HP2K,  K_A1}: q30 = -64'sd1719116810;
      {SEC_HP2K,  K_A2}: q30 = 64'sd717610881;
      default:           q30 = '0;
    endcase
    r = (q30 + (64'sd1 <<< (29 - CF))) >>> (30 - CF);
    return r[MUL_W-1:0];
  endfunction

  function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [MAC_W-1:0] a);
    logic signed [MAC_W-1:0] t;
    t = a >>> CF;
    if (t > SIG_MAX) t = SIG_MAX;
    else if (t < SIG_MIN) t = SIG_MIN;
    return t[SIG_W-1:0];
  endfunction

  function automatic logic signed [DLY_W-1:0] sat_dly(input logic signed [MAC_W-1:0] a);
    logic signed [MAC_W-1:0] t;
    t = a >>> CF;
    if (t > DLY_MAX) t = DLY_MAX;
    else if (t < DLY_MIN) t = DLY_MIN;
    return t[DLY_W-1:0];
  endfunction

  // round half up from fine units back to sample lsbs
  function automatic logic signed [BAND_W-1:0] band_round(input logic signed [SIG_W-1:0] y);
    logic signed [SIG_W:0] t;
    t = ($signed({y[SIG_W-1], y}) + (SIG_W + 1)'(1 <<< (DF - 1))) >>> DF;
    return t[BAND_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/tbwe_mac.sv @@
// ----------------------------------------------------------------------------
// tbwe_mac
// Shared multiply-accumulate unit: registered product and accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module tbwe_mac (
  input  logic                                   clk,
  input  tbwe_pkg::mac_cmd_t                     cmd,
  input  logic signed [tbwe_pkg::MUL_W-1:0]      mul_a,
  input  logic signed [tbwe_pkg::MUL_W-1:0]      mul_b,
  input  logic signed [tbwe_pkg::MAC_W-1:0]      load_val,
  output logic signed [tbwe_pkg::MAC_W-1:0]      acc,
  output logic signed [tbwe_pkg::MAC_W-1:0]      prod
);
  import tbwe_pkg::*;

  logic signed [MAC_W-1:0] prod_r;
  logic signed [MAC_W-1:0] acc_r;
  logic signed [MAC_W-1:0] prod_full;

  assign prod_full = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= prod_full;
    end
    unique case (cmd.op)
      ACC_HOLD:    acc_r <= acc_r;
      ACC_LOAD:    acc_r <= load_val;
      ACC_ADD:     acc_r <= acc_r + prod_r;
      ACC_SUB:     acc_r <= acc_r - prod_r;
      ACC_LOADADD: acc_r <= load_val + prod_r;
      default:     acc_r <= acc_r;
    endcase
  end

  assign acc  = acc_r;
  assign prod = prod_r;

endmodule

`default_nettype wire

@@ sv/tbwe_div.sv @@
// ----------------------------------------------------------------------------
// tbwe_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tbwe_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tbwe_pkg::ACC_W-1:0]    dividend,
  input  logic [tbwe_pkg::CNT_W-1:0]    divisor,
  output logic                          done,
  output logic [tbwe_pkg::ACC_W-1:0]    quotient
);
  import tbwe_pkg::*;

  localparam int CW = $clog2(ACC_W);

  logic [ACC_W-1:0] q_r;
  logic [CNT_W:0]   rem_r;
  logic [CNT_W-1:0] d_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   diff;
  logic             fits;

  assign trial = {rem_r[CNT_W-1:0], q_r[ACC_W-1]};
  assign fits  = trial >= {1'b0, d_r};
  assign diff  = trial - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r    <= dividend;
        rem_r  <= '0;
        d_r    <= divisor;
        cnt_r  <= CW'(ACC_W - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? diff : trial;
        q_r   <= {q_r[ACC_W-2:0], fits};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

`default_nettype wire

@@ sv/tbwe_isqrt.sv @@
// ----------------------------------------------------------------------------
// tbwe_isqrt
// Floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tbwe_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tbwe_pkg::ACC_W-1:0]    radicand,
  output logic                          done,
  output logic [tbwe_pkg::ROOT_W-1:0]   root
);
  import tbwe_pkg::*;

  localparam int CW  = $clog2(ROOT_W);
  localparam int REM_W = ROOT_W + 2;

  logic [ACC_W-1:0]  n_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [REM_W+1:0]  r4;
  logic [REM_W+1:0]  trial;
  logic [REM_W+1:0]  diff;
  logic              fits;

  assign r4    = {rem_r, n_r[ACC_W-1:ACC_W-2]};
  assign trial = {2'b00, root_r, 2'b01};
  assign fits  = r4 >= trial;
  assign diff  = r4 - trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        n_r    <= radicand;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= CW'(ROOT_W - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r  <= fits ? diff[REM_W-1:0] : r4[REM_W-1:0];
        root_r <= {root_r[ROOT_W-2:0], fits};
        n_r    <= {n_r[ACC_W-3:0], 2'b00};
        cnt_r  <= cnt_r - CW'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

@@ sv/three_band_waveform_energy_unit.sv @@
// ----------------------------------------------------------------------------
// three_band_waveform_energy_unit
// Three band biquad split with per-column peak and rms levels.
// ----------------------------------------------------------------------------
// Each sample runs through four biquad sections (low band 200 Hz low-pass,
// mid band 200 Hz high-pass then 2 kHz low-pass, high band 2 kHz high-pass)
// on one shared multiply-accumulate unit, then a square and an add per band
// accumulate the band values; a sample that does not close a column holds
// in_tready low until its band sums are updated. A sample that closes a
// column (count reached or in_tlast) adds the height scaling and, per band,
// a bit-serial divide by the count, a square root and the gain scaling. The
// result waits in an output register, so the next sample is taken while it
// is still unread; out_tready only stalls a later column result.
// ----------------------------------------------------------------------------
`default_nettype none

module three_band_waveform_energy_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [tbwe_pkg::IN_DATA_W-1:0]      in_tdata,   // sample[15:0]
  input  logic                                in_tlast,   // end_of_track
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // height[4:0], low_level[11:5], mid_level[18:12], high_level[25:19], zero
  output logic [tbwe_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tlast,  // last_column
  input  logic                                cfg_we,
  input  logic [tbwe_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [tbwe_pkg::CFG_W-1:0]          cfg_wdata
);
  import tbwe_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FILT, ST_SQ, ST_HMUL, ST_HACC, ST_HCAP, ST_DGO, ST_DWAIT,
    ST_RGO, ST_RWAIT, ST_BMUL, ST_BACC, ST_BCAP, ST_DONE
  } state_t;

  state_t                  state_r, state_nxt;
  logic [4:0]              step_r, step_nxt;
  logic [1:0]              band_r, band_nxt;
  logic signed [SIG_W-1:0] xf_r, xf_nxt;
  logic signed [SIG_W-1:0] y_r, y_nxt;
  logic signed [SIG_W-1:0] ylow_r, ylow_nxt;
  logic signed [SIG_W-1:0] ymidin_r, ymidin_nxt;
  logic signed [SIG_W-1:0] ymid_r, ymid_nxt;
  logic signed [SIG_W-1:0] yhigh_r, yhigh_nxt;
  logic                    eot_r, eot_nxt;
  logic [PEAK_W-1:0]       peak_r, peak_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [ACC_W-1:0]        sum_r [3];
  logic [ACC_W-1:0]        sum_nxt [3];
  logic signed [DLY_W-1:0] z_r [2*NSEC];
  logic signed [DLY_W-1:0] z_nxt [2*NSEC];
  logic [HEIGHT_W-1:0]     height_r, height_nxt;
  logic [LEVEL_W-1:0]      lvl_r [3];
  logic [LEVEL_W-1:0]      lvl_nxt [3];
  logic [OUT_DATA_W-1:0]   out_data_r, out_data_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic [CNT_W-1:0]        spc_r;
  logic [HG_W-1:0]         hg_r;
  logic [BG_W-1:0]         bg_r;

  mac_cmd_t                cmd;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [MAC_W-1:0] load_val, acc, prod;
  logic                    div_start, div_done;
  logic [ACC_W-1:0]        quot;
  logic                    sq_start, sq_done;
  logic [ROOT_W-1:0]       root;

  logic [1:0]              sec;
  logic [2:0]              st;
  logic signed [SIG_W-1:0] sec_x;
  logic signed [DLY_W-1:0] z_rd;
  logic signed [MAC_W-1:0] z_ext;
  logic signed [SIG_W-1:0] ysat;
  logic signed [SIG_W-1:0] band_y;
  logic signed [BAND_W-1:0] bv;
  logic [ACC_W:0]          sq_sum;
  logic signed [SAMPLE_W:0] smp;
  logic [PEAK_W-1:0]       mag;
  logic [HEIGHT_W-1:0]     h_clamp;
  logic [LEVEL_W-1:0]      l_clamp;

  tbwe_mac u_mac (
    .clk(clk), .cmd(cmd), .mul_a(mul_a), .mul_b(mul_b),
    .load_val(load_val), .acc(acc), .prod(prod)
  );

  tbwe_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(sum_r[band_r]),
    .divisor(count_r), .done(div_done), .quotient(quot)
  );

  tbwe_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(quot),
    .done(sq_done), .root(root)
  );

  assign sec   = step_r[4:3];
  assign st    = step_r[2:0];
  // the mid band's second section takes the first one's output
  assign sec_x = (sec == SEC_LP2K) ? ymidin_r : xf_r;
  assign z_rd  = z_r[{sec, (st != 3'd0)}];
  assign z_ext = MAC_W'(z_rd) <<< CF;
  assign ysat  = sat_sig(acc);

  always_comb begin
    unique case (band_r)
      2'd0:    band_y = ylow_r;
      2'd1:    band_y = ymid_r;
      default: band_y = yhigh_r;
    endcase
  end

  assign bv     = band_round(band_y);
  assign sq_sum = {1'b0, sum_r[band_r]} + (ACC_W + 1)'(prod[SQ_W-1:0]);
  assign smp    = $signed({in_tdata[SAMPLE_W-1], in_tdata});
  assign mag    = smp[SAMPLE_W] ? PEAK_W'(-smp) : PEAK_W'(smp);

  assign h_clamp = (|acc[MAC_W-1:GAIN_SHIFT+HEIGHT_W]) ? '1
                 : acc[GAIN_SHIFT+HEIGHT_W-1:GAIN_SHIFT];
  assign l_clamp = (|acc[MAC_W-1:GAIN_SHIFT+LEVEL_W]) ? '1
                 : acc[GAIN_SHIFT+LEVEL_W-1:GAIN_SHIFT];

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    band_nxt     = band_r;
    xf_nxt       = xf_r;
    y_nxt        = y_r;
    ylow_nxt     = ylow_r;
    ymidin_nxt   = ymidin_r;
    ymid_nxt     = ymid_r;
    yhigh_nxt    = yhigh_r;
    eot_nxt      = eot_r;
    peak_nxt     = peak_r;
    count_nxt    = count_r;
    sum_nxt      = sum_r;
    z_nxt        = z_r;
    height_nxt   = height_r;
    lvl_nxt      = lvl_r;
    out_data_nxt = out_data_r;
    out_last_nxt = out_last_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd          = '{mul_en: 1'b0, op: ACC_HOLD};
    mul_a        = '0;
    mul_b        = '0;
    load_val     = '0;
    div_start    = 1'b0;
    sq_start     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          xf_nxt  = SIG_W'(smp) <<< DF;
          eot_nxt = in_tlast;
          if (mag > peak_r) peak_nxt = mag;
          if (count_r != '1) count_nxt = count_r + CNT_W'(1);
          step_nxt  = '0;
          state_nxt = ST_FILT;
        end
      end

      // transposed direct form ii, one product at a time on the shared unit
      ST_FILT: begin
        unique case (st)
          3'd0: begin
            cmd      = '{mul_en: 1'b1, op: ACC_LOAD};
            mul_a    = coef_q(sec, K_B0);
            mul_b    = MUL_W'(sec_x);
            load_val = z_ext + HALF_CF;
          end
          3'd1: cmd = '{mul_en: 1'b0, op: ACC_ADD};
          3'd2: begin
            cmd      = '{mul_en: 1'b1, op: ACC_LOAD};
            mul_a    = coef_q(sec, K_B1);
            mul_b    = MUL_W'(sec_x);
            load_val = z_ext + HALF_CF;
            y_nxt    = ysat;
            unique case (sec)
              SEC_LP200: ylow_nxt   = ysat;
              SEC_HP200: ymidin_nxt = ysat;
              SEC_LP2K:  ymid_nxt   = ysat;
              SEC_HP2K:  yhigh_nxt  = ysat;
              default:   yhigh_nxt  = ysat;
            endcase
          end
          3'd3: begin
            cmd   = '{mul_en: 1'b1, op: ACC_ADD};
            mul_a = coef_q(sec, K_A1);
            mul_b = MUL_W'(y_r);
          end
          3'd4: begin
            cmd   = '{mul_en: 1'b1, op: ACC_SUB};
            mul_a = coef_q(sec, K_B2);
            mul_b = MUL_W'(sec_x);
          end
          3'd5: begin
            cmd      = '{mul_en: 1'b1, op: ACC_LOADADD};
            mul_a    = coef_q(sec, K_A2);
            mul_b    = MUL_W'(y_r);
            load_val = HALF_CF;
            z_nxt[{sec, 1'b0}] = sat_dly(acc);
          end
          3'd6: cmd = '{mul_en: 1'b0, op: ACC_SUB};
          default: z_nxt[{sec, 1'b1}] = sat_dly(acc);
        endcase
        step_nxt = step_r + 5'd1;
        if (step_r == '1) begin
          band_nxt  = '0;
          state_nxt = ST_SQ;
        end
      end

      ST_SQ: begin
        if (!step_r[0]) begin
          cmd      = '{mul_en: 1'b1, op: ACC_HOLD};
          mul_a    = MUL_W'(bv);
          mul_b    = MUL_W'(bv);
          step_nxt = step_r + 5'd1;
        end else begin
          sum_nxt[band_r] = sq_sum[ACC_W] ? '1 : sq_sum[ACC_W-1:0];
          step_nxt = '0;
          if (band_r == 2'd2) begin
            band_nxt  = '0;
            state_nxt = (eot_r || count_r >= spc_r) ? ST_HMUL : ST_IDLE;
          end else begin
            band_nxt = band_r + 2'd1;
          end
        end
      end

      ST_HMUL: begin
        cmd       = '{mul_en: 1'b1, op: ACC_HOLD};
        mul_a     = MUL_W'(peak_r);
        mul_b     = MUL_W'(hg_r);
        state_nxt = ST_HACC;
      end
      ST_HACC: begin
        cmd       = '{mul_en: 1'b0, op: ACC_LOADADD};
        load_val  = HALF_G;
        state_nxt = ST_HCAP;
      end
      ST_HCAP: begin
        height_nxt = h_clamp;
        state_nxt  = ST_DGO;
      end

      ST_DGO: begin
        div_start = 1'b1;
        state_nxt = ST_DWAIT;
      end
      ST_DWAIT: if (div_done) state_nxt = ST_RGO;
      ST_RGO: begin
        sq_start  = 1'b1;
        state_nxt = ST_RWAIT;
      end
      ST_RWAIT: if (sq_done) state_nxt = ST_BMUL;
      ST_BMUL: begin
        cmd       = '{mul_en: 1'b1, op: ACC_HOLD};
        mul_a     = MUL_W'(root);
        mul_b     = MUL_W'(bg_r);
        state_nxt = ST_BACC;
      end
      ST_BACC: begin
        cmd       = '{mul_en: 1'b0, op: ACC_LOADADD};
        load_val  = HALF_G;
        state_nxt = ST_BCAP;
      end
      ST_BCAP: begin
        lvl_nxt[band_r] = l_clamp;
        if (band_r == 2'd2) begin
          state_nxt = ST_DONE;
        end else begin
          band_nxt  = band_r + 2'd1;
          state_nxt = ST_DGO;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_DATA_W'({lvl_r[2], lvl_r[1], lvl_r[0], height_r});
          out_last_nxt  = eot_r;
          for (int i = 0; i < 3; i++) sum_nxt[i] = '0;
          peak_nxt  = '0;
          count_nxt = '0;
          if (eot_r) begin
            for (int i = 0; i < 2 * NSEC; i++) z_nxt[i] = '0;
          end
          band_nxt  = '0;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      band_r      <= '0;
      eot_r       <= 1'b0;
      peak_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) sum_r[i] <= '0;
      for (int i = 0; i < 2 * NSEC; i++) z_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      band_r      <= band_nxt;
      eot_r       <= eot_nxt;
      peak_r      <= peak_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      sum_r       <= sum_nxt;
      z_r         <= z_nxt;
    end
    xf_r       <= xf_nxt;
    y_r        <= y_nxt;
    ylow_r     <= ylow_nxt;
    ymidin_r   <= ymidin_nxt;
    ymid_r     <= ymid_nxt;
    yhigh_r    <= yhigh_nxt;
    height_r   <= height_nxt;
    lvl_r      <= lvl_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spc_r <= SPC_RESET;
      hg_r  <= HG_RESET;
      bg_r  <= BG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SPC: spc_r <= cfg_wdata[CNT_W-1:0];
        REG_HG:  hg_r  <= cfg_wdata[HG_W-1:0];
        REG_BG:  bg_r  <= cfg_wdata[BG_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("block ready right after an input transfer");

  a_done_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !out_valid_r) |=> out_valid_r)
    else $error("finished column not loaded into empty output register");

  a_column_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (count_r == '0 && peak_r == '0))
    else $error("column accumulators not cleared on result");

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DWAIT))
    else $error("divider finished outside its wait state");

endmodule

`default_nettype wire
